// ===== rtl/core/ckpb_pkg.sv =====
// Package for the palette color map with blend: word types, register map,
// key and blend codes, and the palette geometry.
// No dependencies.
package ckpb_pkg;

  localparam int unsigned PAL_DEPTH   = 256;
  localparam int unsigned PAL_AW      = $clog2(PAL_DEPTH);
  localparam int unsigned COLOR_W     = 24;
  localparam int unsigned PIXEL_W     = 32;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 8;

  // floor(s/3) for s <= 765 as (s * 683) >> 11
  localparam int unsigned DIV3_MUL    = 683;
  localparam int unsigned DIV3_SHIFT  = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_MODE   = 2'd0,
    REG_BLEND_MODE = 2'd1,
    REG_ALPHA      = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    KEY_RED   = 3'd0,
    KEY_GREEN = 3'd1,
    KEY_BLUE  = 3'd2,
    KEY_HALF  = 3'd3,
    KEY_MAX   = 3'd4,
    KEY_AVG   = 3'd5
  } key_mode_e;

  typedef enum logic [3:0] {
    BL_REPLACE = 4'd0,
    BL_ADD     = 4'd1,
    BL_MAX     = 4'd2,
    BL_MIN     = 4'd3,
    BL_AVG     = 4'd4,
    BL_SUB_PIX = 4'd5,
    BL_SUB_PAL = 4'd6,
    BL_MUL     = 4'd7,
    BL_XOR     = 4'd8,
    BL_ALPHA   = 4'd9
  } blend_mode_e;

  typedef struct packed {
    logic [2:0] key_mode;
    logic [3:0] blend_mode;
    logic [7:0] alpha;
  } cfg_t;

  typedef struct packed {
    logic               cmd;
    logic [PIXEL_W-1:0] pixel;
    logic               last_pixel;
    logic [PAL_AW-1:0]  entry_index;
    logic [COLOR_W-1:0] entry_color;
  } in_word_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_out;
    logic               last_out;
  } out_word_t;

endpackage

// ===== rtl/core/ckpb_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module ckpb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/ckpb_key.sv =====
// Key extraction: reduces a pixel to the 8-bit palette index.
// Depends on ckpb_pkg.
module ckpb_key (
  input  ckpb_pkg::cfg_t                  cfg_i,
  input  logic [ckpb_pkg::PIXEL_W-1:0]    pixel_i,
  output logic [ckpb_pkg::PAL_AW-1:0]     key_o
);

  logic [7:0]  r, g, b, rg_max;
  logic [9:0]  sum;
  logic [8:0]  half;
  logic [19:0] div3_prod;

  assign b   = pixel_i[7:0];
  assign g   = pixel_i[15:8];
  assign r   = pixel_i[23:16];
  assign sum = 10'(r) + 10'(g) + 10'(b);
  assign half = sum[9:1];
  assign rg_max = (r > g) ? r : g;
  // divide by three via reciprocal multiply
  assign div3_prod = 20'(sum) * 20'(ckpb_pkg::DIV3_MUL);

  always_comb begin
    unique case (cfg_i.key_mode)
      ckpb_pkg::KEY_RED:   key_o = r;
      ckpb_pkg::KEY_GREEN: key_o = g;
      ckpb_pkg::KEY_BLUE:  key_o = b;
      ckpb_pkg::KEY_HALF:  key_o = half[8] ? 8'hff : half[7:0];
      ckpb_pkg::KEY_MAX:   key_o = (rg_max > b) ? rg_max : b;
      default:             key_o = div3_prod[ckpb_pkg::DIV3_SHIFT +: 8];
    endcase
  end

endmodule

// ===== rtl/core/ckpb_blend.sv =====
// Bytewise combine of pixel and palette color, four byte lanes.
// Depends on ckpb_pkg.
module ckpb_blend (
  input  ckpb_pkg::cfg_t                 cfg_i,
  input  logic [ckpb_pkg::PIXEL_W-1:0]   pixel_i,
  input  logic [ckpb_pkg::COLOR_W-1:0]   color_i,
  output logic [ckpb_pkg::PIXEL_W-1:0]   pixel_o
);

  logic [ckpb_pkg::PIXEL_W-1:0] color_ext;
  logic [7:0]                   alpha_inv;

  // palette has no fourth byte
  assign color_ext = {8'h00, color_i};
  assign alpha_inv = 8'hff - cfg_i.alpha;

  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic [7:0]  p, c, res;
    logic [8:0]  add_sum, avg_sum;
    logic [15:0] mul_prod, pa_prod, ca_prod;
    logic [16:0] alpha_sum;

    assign p = pixel_i[8*l +: 8];
    assign c = color_ext[8*l +: 8];
    assign add_sum   = 9'(p) + 9'(c);
    assign avg_sum   = 9'(p) + 9'(c) + 9'd1;
    assign mul_prod  = 16'(p) * 16'(c);
    assign pa_prod   = 16'(p) * 16'(alpha_inv);
    assign ca_prod   = 16'(c) * 16'(cfg_i.alpha);
    assign alpha_sum = 17'(pa_prod) + 17'(ca_prod);

    always_comb begin
      unique case (cfg_i.blend_mode)
        ckpb_pkg::BL_REPLACE: res = c;
        ckpb_pkg::BL_ADD:     res = add_sum[8] ? 8'hff : add_sum[7:0];
        ckpb_pkg::BL_MAX:     res = (p > c) ? p : c;
        ckpb_pkg::BL_MIN:     res = (p < c) ? p : c;
        ckpb_pkg::BL_AVG:     res = avg_sum[8:1];
        ckpb_pkg::BL_SUB_PIX: res = (p > c) ? p - c : 8'h00;
        ckpb_pkg::BL_SUB_PAL: res = (c > p) ? c - p : 8'h00;
        ckpb_pkg::BL_MUL:     res = mul_prod[15:8];
        ckpb_pkg::BL_XOR:     res = p ^ c;
        ckpb_pkg::BL_ALPHA:   res = alpha_sum[15:8];
        default:              res = p;
      endcase
    end

    assign pixel_o[8*l +: 8] = res;
  end

endmodule

// ===== rtl/core/color_key_palette_blend.sv =====
// Top level of the palette color map with blend: key stage, palette RAM,
// blend stage and output register. Depends on ckpb_pkg, ckpb_key,
// ckpb_ram and ckpb_blend.
//
//   port group   | direction | word / fields
//   -------------+-----------+--------------------------------------------
//   in           | in        | in_word_i: cmd, pixel, last_pixel, index, color
//   out          | out       | out_word_o: pixel_out, last_out
//   cfg          | in        | cfg_we_i, cfg_idx_i, cfg_data_i
//
// One word per cycle while in_stall_o is low. The key addresses the palette
// read at acceptance; the read data is blended and registered into the output
// register when the read stage advances. A palette write is done at its
// acceptance edge and gives no output word.
// Reset clears the pipeline valids and the config register; the data registers and palette are not reset.
// Output stall holds the output register, then the read stage, then input.
module color_key_palette_blend (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  ckpb_pkg::in_word_t                  in_word_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output ckpb_pkg::out_word_t                 out_word_o,
  input  logic                                cfg_we_i,
  input  logic [ckpb_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ckpb_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  ckpb_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ckpb_pkg::REG_KEY_MODE:   cfg_q.key_mode   <= cfg_data_i[2:0];
        ckpb_pkg::REG_BLEND_MODE: cfg_q.blend_mode <= cfg_data_i[3:0];
        ckpb_pkg::REG_ALPHA:      cfg_q.alpha      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic                            in_acc;
  logic                            rd_en;
  logic                            wr_en;
  logic                            s1_adv;
  logic [ckpb_pkg::PAL_AW-1:0]     key;
  logic [ckpb_pkg::COLOR_W-1:0]    pal_color;
  logic [ckpb_pkg::PIXEL_W-1:0]    blended;

  logic                            s1_valid_q;
  logic [ckpb_pkg::PIXEL_W-1:0]    s1_pixel_q;
  logic                            s1_last_q;
  logic                            out_valid_q;
  ckpb_pkg::out_word_t             out_word_q;

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign rd_en      = in_acc && !in_word_i.cmd;
  assign wr_en      = in_acc && in_word_i.cmd;

  ckpb_key u_key (
    .cfg_i   (cfg_q),
    .pixel_i (in_word_i.pixel),
    .key_o   (key)
  );

  // read data only updates on a pixel accept, so it holds while stage 1 waits
  ckpb_ram #(
    .Width (ckpb_pkg::COLOR_W),
    .Depth (ckpb_pkg::PAL_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (in_word_i.entry_index),
    .wdata_i (in_word_i.entry_color),
    .re_i    (rd_en),
    .raddr_i (key),
    .rdata_o (pal_color)
  );

  ckpb_blend u_blend (
    .cfg_i   (cfg_q),
    .pixel_i (s1_pixel_q),
    .color_i (pal_color),
    .pixel_o (blended)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // stage 1 refills whenever it is empty or moving on
      if (!in_stall_o) begin
        s1_valid_q <= rd_en;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s1_pixel_q <= in_word_i.pixel;
      s1_last_q  <= in_word_i.last_pixel;
    end
    if (s1_adv && s1_valid_q) begin
      out_word_q.pixel_out <= blended;
      out_word_q.last_out  <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

`ifndef NO_ASSERTIONS
  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty read stage");

  a_pixel_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |=> s1_valid_q)
    else $error("accepted pixel lost before read stage");

  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> !s1_valid_q)
    else $error("palette write produced a pixel word");

  a_advance_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_adv) |=> out_valid_o)
    else $error("read stage word did not reach output register");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for color_key_palette_blend: loads the palette, walks a
// directed table, then runs phases of random pixel and palette words.
// Depends on ckpb_pkg and the color_key_palette_blend RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ckpb_pkg::*;

  localparam logic CMD_PIXEL  = 1'b0;
  localparam logic CMD_PAL_WR = 1'b1;
  localparam int   N_PHASE    = 20;
  localparam int   PHASE_WORDS = 25;
  localparam int   HOLD_CYCLES = 80;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_word;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_word;
  logic        cfg_we;
  reg_idx_e    cfg_idx;
  logic [7:0]  cfg_data;

  color_key_palette_blend uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  // shadow of the block state
  logic [COLOR_W-1:0] pal_mem [PAL_DEPTH];
  logic [2:0]         key_sel;
  logic [3:0]         blend_sel;
  logic [7:0]         alpha_w;

  out_word_t pending_px[$];
  int        errors;
  int        px_checked;
  int        pal_writes;
  int        settings;

  // idling controls
  bit quiet;
  bit gappy;
  bit rx_idle;
  bit hold_req;

  typedef struct {
    bit         is_cfg;
    reg_idx_e   idx;
    logic [7:0] data;
    in_word_t   w;
    bit         typed;
    out_word_t  want;
  } row_t;

  row_t dir_rows[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // ---------------- predictor ----------------

  function automatic logic [7:0] key_of(logic [31:0] px);
    logic [7:0] b, g, r, m;
    logic [9:0] s;
    b = px[7:0];
    g = px[15:8];
    r = px[23:16];
    s = r + g + b;
    case (key_sel)
      KEY_RED:   return r;
      KEY_GREEN: return g;
      KEY_BLUE:  return b;
      KEY_HALF:  return (s[9:1] > 9'd255) ? 8'hFF : s[8:1];
      KEY_MAX: begin
        m = (r > g) ? r : g;
        return (m > b) ? m : b;
      end
      default:   return 8'(s / 10'd3);  // codes 6 and 7 fall back to the average
    endcase
  endfunction

  function automatic logic [7:0] mix_byte(logic [7:0] p, logic [7:0] c);
    logic [8:0]  t;
    logic [15:0] w;
    case (blend_sel)
      BL_REPLACE: return c;
      BL_ADD: begin
        t = p + c;
        return t[8] ? 8'hFF : t[7:0];
      end
      BL_MAX:     return (p > c) ? p : c;
      BL_MIN:     return (p < c) ? p : c;
      BL_AVG: begin
        t = p + c + 9'd1;
        return t[8:1];
      end
      BL_SUB_PIX: return (p > c) ? p - c : 8'd0;
      BL_SUB_PAL: return (c > p) ? c - p : 8'd0;
      BL_MUL: begin
        w = p * c;
        return w[15:8];
      end
      BL_XOR:     return p ^ c;
      BL_ALPHA: begin
        w = p * (16'd255 - alpha_w) + c * alpha_w;
        return w[15:8];
      end
      default:    return p;
    endcase
  endfunction

  function automatic out_word_t blend_pixel(logic [31:0] px, logic last);
    out_word_t   o;
    logic [31:0] col;
    col = {8'h00, pal_mem[key_of(px)]};
    for (int i = 0; i < 4; i++)
      o.pixel_out[8*i +: 8] = mix_byte(px[8*i +: 8], col[8*i +: 8]);
    o.last_out = last;
    return o;
  endfunction

  // word accepted by the block: update shadow palette or queue the result
  function automatic void take_word(in_word_t w, bit typed, out_word_t want);
    if (w.cmd == CMD_PAL_WR) begin
      pal_mem[w.entry_index] = w.entry_color;
      pal_writes++;
    end else begin
      pending_px.push_back(typed ? want : blend_pixel(w.pixel, w.last_pixel));
    end
  endfunction

  function automatic void check_word(out_word_t got);
    out_word_t want;
    if (pending_px.size() == 0) begin
      $display("%0t: unexpected output word, got %h/%b", $time, got.pixel_out,
               got.last_out);
      errors++;
      return;
    end
    want = pending_px.pop_front();
    px_checked++;
    if (got.pixel_out !== want.pixel_out) begin
      $display("%0t: pixel_out expected %h got %h", $time, want.pixel_out, got.pixel_out);
      errors++;
    end
    if (got.last_out !== want.last_out) begin
      $display("%0t: last_out expected %b got %b", $time, want.last_out, got.last_out);
      errors++;
    end
  endfunction

  // ---------------- directed table ----------------

  function automatic row_t blank_row();
    row_t r;
    r.is_cfg = 1'b0;
    r.idx    = REG_KEY_MODE;
    r.data   = '0;
    r.w      = '0;
    r.typed  = 1'b0;
    r.want   = '0;
    return r;
  endfunction

  function automatic void add_cfg(reg_idx_e idx, logic [7:0] data);
    row_t r;
    r = blank_row();
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_wr(logic [7:0] idx, logic [23:0] color);
    row_t r;
    r = blank_row();
    r.w.cmd         = CMD_PAL_WR;
    r.w.pixel       = 32'hFFFF_FFFF;
    r.w.last_pixel  = 1'b1;
    r.w.entry_index = idx;
    r.w.entry_color = color;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_px(logic [31:0] px, logic last);
    row_t r;
    r = blank_row();
    r.w.cmd        = CMD_PIXEL;
    r.w.pixel      = px;
    r.w.last_pixel = last;
    r.w.entry_index = 8'hFF;
    r.w.entry_color = 24'hFFFFFF;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_chk(logic [31:0] px, logic last, logic [31:0] res);
    add_px(px, last);
    dir_rows[$].typed          = 1'b1;
    dir_rows[$].want.pixel_out = res;
    dir_rows[$].want.last_out  = last;
  endfunction

  // ---------------- driving ----------------

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_word(in_word_t w, bit typed, out_word_t want);
    in_word  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    take_word(w, typed, want);
  endtask

  task automatic maybe_gap();
    if (!quiet && gappy && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // stop offering and wait until every queued pixel has come out
  task automatic quiesce();
    if (in_valid) in_valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [7:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_KEY_MODE:   key_sel   = data[2:0];
      REG_BLEND_MODE: blend_sel = data[3:0];
      REG_ALPHA:      alpha_w   = data;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------- receiver ----------------

  initial begin : rx_side
    int hold_left;
    int burst_left;
    bit held;
    bit stall_nxt;
    hold_left  = 0;
    burst_left = 0;
    held       = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) check_word(out_word);
      if (hold_req && !held) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_nxt = 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        stall_nxt = 1'b1;
      end else if (!quiet && rx_idle && $urandom_range(0, 7) == 0) begin
        burst_left = $urandom_range(0, 7);
        stall_nxt  = 1'b1;
      end else begin
        stall_nxt = 1'b0;
      end
      out_stall <= stall_nxt;
    end
  end

  // ---------------- stimulus ----------------

  initial begin : tx_side
    in_word_t   w;
    logic [2:0] k;
    logic [3:0] b;
    logic [7:0] a;

    errors     = 0;
    px_checked = 0;
    pal_writes = 0;
    settings   = 1;
    quiet      = 1'b0;
    gappy      = 1'b1;
    rx_idle    = 1'b1;
    hold_req   = 1'b0;
    key_sel    = KEY_RED;
    blend_sel  = BL_REPLACE;
    alpha_w    = 8'h00;
    foreach (pal_mem[i]) pal_mem[i] = '0;

    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_word  <= '0;
    cfg_we   <= 1'b0;
    cfg_idx  <= REG_KEY_MODE;
    cfg_data <= '0;

    // directed rows; typed results assume entries 0 and 255 as written here
    add_wr(8'h00, 24'h123456);
    add_wr(8'hFF, 24'hABCDEF);
    add_chk(32'h0000_0000, 1'b0, 32'h0012_3456);
    add_chk(32'hFFFF_FFFF, 1'b1, 32'h00AB_CDEF);
    add_cfg(REG_BLEND_MODE, 8'(BL_ADD));
    add_chk(32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF);
    add_chk(32'h0000_0000, 1'b1, 32'h0012_3456);
    add_cfg(REG_BLEND_MODE, 8'(BL_XOR));
    add_chk(32'hFFFF_FFFF, 1'b0, 32'hFF54_3210);
    add_px(32'h5AA5_3CC3, 1'b0);
    add_cfg(REG_BLEND_MODE, 8'(BL_SUB_PIX));
    add_chk(32'h0000_0000, 1'b0, 32'h0000_0000);
    add_chk(32'hFFFF_FFFF, 1'b0, 32'hFF54_3210);
    add_cfg(REG_BLEND_MODE, 8'(BL_SUB_PAL));
    add_chk(32'h0000_0000, 1'b0, 32'h0012_3456);
    add_chk(32'hFFFF_FFFF, 1'b1, 32'h0000_0000);
    add_cfg(REG_BLEND_MODE, 8'(BL_MUL));
    add_chk(32'hFFFF_FFFF, 1'b0, 32'h00AA_CCEE);
    add_cfg(REG_ALPHA, 8'hFF);
    add_cfg(REG_BLEND_MODE, 8'(BL_ALPHA));
    add_chk(32'h0000_0000, 1'b0, 32'h0011_3355);
    add_chk(32'hFFFF_FFFF, 1'b0, 32'h00AA_CCEE);
    add_cfg(REG_ALPHA, 8'h00);
    add_chk(32'hFFFF_FFFF, 1'b0, 32'hFEFE_FEFE);
    // undefined blend code passes the pixel through
    add_cfg(REG_BLEND_MODE, 8'd15);
    add_chk(32'hA5C3_5A00, 1'b1, 32'hA5C3_5A00);
    // undefined key codes act as the average key
    add_cfg(REG_KEY_MODE, 8'd7);
    add_cfg(REG_BLEND_MODE, 8'(BL_AVG));
    add_chk(32'h00FF_FFFF, 1'b0, 32'h00D5_E6F7);
    add_cfg(REG_KEY_MODE, 8'd6);
    add_px(32'hC040_8020, 1'b0);
    add_cfg(REG_KEY_MODE, 8'(KEY_HALF));
    add_cfg(REG_BLEND_MODE, 8'(BL_MAX));
    add_chk(32'h00FF_FFFF, 1'b0, 32'h00FF_FFFF);
    add_px(32'h0010_2030, 1'b0);
    add_cfg(REG_KEY_MODE, 8'(KEY_MAX));
    add_cfg(REG_BLEND_MODE, 8'(BL_MIN));
    add_chk(32'h7F00_FF00, 1'b0, 32'h0000_CD00);
    add_cfg(REG_KEY_MODE, 8'(KEY_AVG));
    add_cfg(REG_BLEND_MODE, 8'(BL_REPLACE));
    add_chk(32'h0001_0100, 1'b0, 32'h0012_3456);
    add_cfg(REG_KEY_MODE, 8'(KEY_GREEN));
    add_chk(32'h0000_FF00, 1'b0, 32'h00AB_CDEF);
    add_cfg(REG_KEY_MODE, 8'(KEY_BLUE));
    add_chk(32'h0000_00FF, 1'b1, 32'h00AB_CDEF);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // load every entry first so no pixel ever reads an unwritten one
    for (int i = 0; i < PAL_DEPTH; i++) begin
      w             = '0;
      w.cmd         = CMD_PAL_WR;
      w.pixel       = $urandom;
      w.last_pixel  = 1'($urandom_range(0, 1));
      w.entry_index = 8'(i);
      w.entry_color = 24'($urandom);
      maybe_gap();
      send_word(w, 1'b0, '0);
    end

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        quiesce();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
        settings++;
      end else begin
        maybe_gap();
        send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    for (int ph = 0; ph < N_PHASE; ph++) begin
      // sweep every blend code once, then alpha extremes, then random settings
      if (ph < 16) begin
        b = 4'(ph);
        k = 3'(ph % 8);
        a = 8'($urandom);
      end else if (ph == 16) begin
        b = BL_ALPHA;
        k = 3'($urandom_range(0, 7));
        a = 8'h00;
      end else if (ph == 17) begin
        b = BL_ALPHA;
        k = 3'($urandom_range(0, 7));
        a = 8'hFF;
      end else begin
        b = 4'($urandom_range(0, 15));
        k = 3'($urandom_range(0, 7));
        a = 8'($urandom);
      end
      quiesce();
      // unused high bits of the write data carry noise
      write_reg(REG_KEY_MODE, {5'($urandom), k});
      write_reg(REG_BLEND_MODE, {4'($urandom), b});
      write_reg(REG_ALPHA, a);
      settings++;
      quiet   = (ph >= N_PHASE - 3);
      gappy   = (ph % 4) != 3;
      rx_idle = (ph % 3) != 1;
      if (ph == 5) hold_req <= 1'b1;
      repeat (PHASE_WORDS) begin
        w             = '0;
        w.cmd         = ($urandom_range(0, 6) == 0) ? CMD_PAL_WR : CMD_PIXEL;
        w.pixel       = {rand_byte(), rand_byte(), rand_byte(), rand_byte()};
        w.last_pixel  = ($urandom_range(0, 15) == 0);
        w.entry_index = 8'($urandom_range(0, 255));
        w.entry_color = 24'($urandom);
        maybe_gap();
        send_word(w, 1'b0, '0);
      end
    end

    quiesce();
    repeat (8) @(posedge clk);
    if (pending_px.size() != 0) begin
      $display("%0t: %0d expected pixel words never came out", $time, pending_px.size());
      errors++;
    end

    $display("Checked %0d blended pixels and %0d palette loads across %0d register settings,",
             px_checked, pal_writes, settings);
    $display("every key and blend code, alpha extremes, and a long output hold.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/ckpb_pkg.sv
rtl/core/ckpb_ram.sv
rtl/core/ckpb_key.sv
rtl/core/ckpb_blend.sv
rtl/core/color_key_palette_blend.sv
tb/tb.sv
